[rtl/ccfd_pkg.sv]
// Shared types, codes and CRC helpers for the COBS/CRC frame decoder.
package ccfd_pkg;

    localparam int MAX_PAYLOAD_DEF  = 8;
    localparam int BUFFER_BYTES_DEF = 16;
    localparam int PACKET_BYTES_DEF = 12;

    // Decoded byte count fits any packet size up to 31
    localparam int CNT_W = 5;
    localparam int PAY_LANES = 8;

    localparam logic [2:0] ST_STORED   = 3'd0;
    localparam logic [2:0] ST_OK       = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_FORMAT   = 3'd3;
    localparam logic [2:0] ST_CRC      = 3'd4;
    localparam logic [2:0] ST_EMPTY    = 3'd5;

    localparam logic [1:0] REG_POLY  = 2'd0;
    localparam logic [1:0] REG_INIT  = 2'd1;
    localparam logic [1:0] REG_REFL  = 2'd2;
    localparam logic [1:0] REG_XOR   = 2'd3;

    typedef struct packed {
        logic                     fmt_err;
        logic [CNT_W-1:0]         count;
        logic [7:0]               hdr0;
        logic [7:0]               hdr1;
        logic [7:0]               last1;
        logic [7:0]               last2;
        logic [15:0]              crc_raw;
        logic [8*PAY_LANES-1:0]   pay;
    } ccfd_res_t;

    function automatic logic [7:0] mirror8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] v);
        logic [15:0] r;
        for (int i = 0; i < 16; i++) r[i] = v[15-i];
        return r;
    endfunction

    // One byte through the MSB-first CRC16 shift register
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b,
                                             input logic [15:0] poly);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            r = r[15] ? ({r[14:0], 1'b0} ^ poly) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

[rtl/ccfd_rxbuf.sv]
// Receive buffer memory: one write port, one registered read port.
module ccfd_rxbuf #(
    parameter int BUFFER_BYTES = ccfd_pkg::BUFFER_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [BUFFER_BYTES];

    // Write stored bytes
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end
endmodule

[rtl/ccfd_unstuff.sv]
// COBS walk over the receive buffer with running CRC, header and payload capture.
module ccfd_unstuff #(
    parameter int BUFFER_BYTES = ccfd_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = ccfd_pkg::PACKET_BYTES_DEF,
    localparam int AW = $clog2(BUFFER_BYTES)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [AW:0]         len,
    input  logic [15:0]         crc_polynomial,
    input  logic [15:0]         crc_initial,
    input  logic                crc_reflected,
    output logic [AW-1:0]       rd_addr,
    input  logic [7:0]          rd_data,
    output logic                done,
    output ccfd_pkg::ccfd_res_t res
);
    import ccfd_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_FETCH, S_WALK, S_DONE} state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW:0]        len_reg, len_next;
    logic [7:0]         run_reg, run_next;
    logic               ff_reg, ff_next;
    logic               pend_reg, pend_next;
    ccfd_res_t          res_reg, res_next;

    logic               app_en;
    logic [7:0]         app_byte;
    logic               last_byte;
    logic [7:0]         crc_in;

    assign last_byte = (({1'b0, pos_reg} + 1'b1) == len_reg);
    assign rd_addr   = (state_reg == S_WALK) ? AW'(pos_reg + 1'b1) : '0;
    assign done      = (state_reg == S_DONE);
    assign res       = res_reg;
    assign crc_in    = crc_reflected ? mirror8(res_reg.last2) : res_reg.last2;

    // Decode one stored byte per cycle
    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        run_next   = run_reg;
        ff_next    = ff_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        app_en     = 1'b0;
        app_byte   = 8'h00;
        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    pos_next         = '0;
                    len_next         = len;
                    run_next         = '0;
                    ff_next          = 1'b0;
                    pend_next        = 1'b0;
                    res_next.fmt_err = 1'b0;
                    res_next.count   = '0;
                    res_next.crc_raw = crc_initial;
                    state_next       = S_FETCH;
                end
            end
            S_FETCH: begin
                state_next = S_WALK;
            end
            S_WALK: begin
                if (run_reg == 8'd0) begin
                    // Code byte: flush the zero left by the previous block
                    if (rd_data == 8'd0) begin
                        res_next.fmt_err = 1'b1;
                    end
                    app_en    = pend_reg;
                    run_next  = rd_data - 8'd1;
                    ff_next   = (rd_data == 8'hFF);
                    pend_next = (rd_data == 8'd1);
                end else begin
                    app_en    = 1'b1;
                    app_byte  = rd_data;
                    run_next  = run_reg - 8'd1;
                    pend_next = (run_reg == 8'd1) && !ff_reg;
                end
                if (app_en) begin
                    if (res_reg.count >= CNT_W'(PACKET_BYTES)) begin
                        res_next.fmt_err = 1'b1;
                    end else begin
                        if (res_reg.count >= CNT_W'(2)) begin
                            res_next.crc_raw = crc_byte(res_reg.crc_raw, crc_in,
                                                        crc_polynomial);
                        end
                        if (res_reg.count == CNT_W'(0)) res_next.hdr0 = app_byte;
                        if (res_reg.count == CNT_W'(1)) res_next.hdr1 = app_byte;
                        for (int j = 0; j < PAY_LANES; j++) begin
                            if (int'(res_reg.count) == j + 2) begin
                                res_next.pay[8*j +: 8] = app_byte;
                            end
                        end
                        res_next.last2 = res_reg.last1;
                        res_next.last1 = app_byte;
                        res_next.count = res_reg.count + 1'b1;
                    end
                end
                if (last_byte && run_next != 8'd0) begin
                    res_next.fmt_err = 1'b1;
                end
                pos_next = AW'(pos_reg + 1'b1);
                if (last_byte || res_next.fmt_err) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        pos_reg  <= pos_next;
        len_reg  <= len_next;
        run_reg  <= run_next;
        ff_reg   <= ff_next;
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end
endmodule

[rtl/cobs_crc_frame_decoder_top.sv]
// Top level: byte intake, packet checks, counters and result register.
// Timing: a data byte's result beat is registered and shows in the cycle after acceptance; a delimiter
// after a filled buffer starts a buffer walk with one buffer read per stored byte.
// Intake: no new byte is taken while a result beat waits or the buffer walk runs.
// Reset: aresetn (synchronous) empties the buffer, zeros counters, restores CRC registers.
module cobs_crc_frame_decoder_top #(
    parameter int MAX_PAYLOAD  = ccfd_pkg::MAX_PAYLOAD_DEF,
    parameter int BUFFER_BYTES = ccfd_pkg::BUFFER_BYTES_DEF,
    parameter int PACKET_BYTES = ccfd_pkg::PACKET_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // line_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, frame_id, payload_length, payload_bytes, good_frame_count,
    // crc_error_count, format_error_count, overflow_count, zero pad
    output logic [215:0] m_tdata,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [15:0]  cfg_wr_data
);
    import ccfd_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_START, S_WALK} state_t;

    state_t        state_reg;
    logic [15:0]   poly_reg, init_reg, xor_reg;
    logic          refl_reg;
    logic [AW:0]   fill_reg, len_reg;
    logic          over_reg;
    logic [31:0]   good_reg, crcerr_reg, fmterr_reg, ovf_reg;
    logic [31:0]   good_next, crcerr_next, fmterr_next, ovf_next;
    logic          m_valid_reg;
    logic [2:0]    status_reg, status_next;
    logic [10:0]   id_reg, id_next;
    logic [3:0]    plen_reg, plen_next;
    logic [63:0]   pay_reg, pay_next;

    logic          accept;
    logic          wr_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic          walk_done;
    ccfd_res_t     res;
    logic [15:0]   crc_calc;
    logic [3:0]    dlc;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign wr_en    = accept && (s_tdata != 8'd0) && (fill_reg < (AW+1)'(BUFFER_BYTES));
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, ovf_reg, fmterr_reg, crcerr_reg, good_reg,
                       pay_reg, plen_reg, id_reg, status_reg};

    ccfd_rxbuf #(.BUFFER_BYTES(BUFFER_BYTES)) u_rxbuf (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ccfd_unstuff #(.BUFFER_BYTES(BUFFER_BYTES), .PACKET_BYTES(PACKET_BYTES)) u_unstuff (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (state_reg == S_START),
        .len            (len_reg),
        .crc_polynomial (poly_reg),
        .crc_initial    (init_reg),
        .crc_reflected  (refl_reg),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .done           (walk_done),
        .res            (res)
    );

    // Finish the CRC and check the decoded packet
    assign crc_calc = (refl_reg ? mirror16(res.crc_raw) : res.crc_raw) ^ xor_reg;
    assign dlc      = res.hdr1[7:4];

    always_comb begin
        status_next = ST_FORMAT;
        id_next     = '0;
        plen_next   = '0;
        pay_next    = '0;
        good_next   = good_reg;
        crcerr_next = crcerr_reg;
        fmterr_next = fmterr_reg;
        if (res.fmt_err || res.count < CNT_W'(4)) begin
            fmterr_next = fmterr_reg + 32'd1;
        end else if ({res.last1, res.last2} != crc_calc) begin
            status_next = ST_CRC;
            crcerr_next = crcerr_reg + 32'd1;
        end else if (int'(dlc) > MAX_PAYLOAD ||
                     ({2'b0, dlc} + 6'd4) != {1'b0, res.count}) begin
            fmterr_next = fmterr_reg + 32'd1;
        end else begin
            status_next = ST_OK;
            good_next   = good_reg + 32'd1;
            id_next     = {res.hdr1[2:0], res.hdr0};
            plen_next   = dlc;
            for (int k = 0; k < PAY_LANES; k++) begin
                if (k < int'(dlc)) pay_next[8*k +: 8] = res.pay[8*k +: 8];
            end
        end
        ovf_next = ovf_reg;
    end

    // Hold configuration, intake state, counters and the result beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            poly_reg    <= 16'h1021;
            init_reg    <= 16'hFFFF;
            refl_reg    <= 1'b0;
            xor_reg     <= 16'h0000;
            fill_reg    <= '0;
            over_reg    <= 1'b0;
            good_reg    <= '0;
            crcerr_reg  <= '0;
            fmterr_reg  <= '0;
            ovf_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_POLY: poly_reg <= cfg_wr_data;
                    REG_INIT: init_reg <= cfg_wr_data;
                    REG_REFL: refl_reg <= cfg_wr_data[0];
                    REG_XOR:  xor_reg  <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        status_reg <= ST_STORED;
                        id_reg     <= '0;
                        plen_reg   <= '0;
                        pay_reg    <= '0;
                        if (s_tdata != 8'd0) begin
                            if (fill_reg < (AW+1)'(BUFFER_BYTES)) begin
                                fill_reg <= fill_reg + 1'b1;
                            end else begin
                                over_reg <= 1'b1;
                            end
                            m_valid_reg <= 1'b1;
                        end else begin
                            fill_reg <= '0;
                            over_reg <= 1'b0;
                            len_reg  <= fill_reg;
                            if (over_reg) begin
                                status_reg  <= ST_OVERFLOW;
                                ovf_reg     <= ovf_reg + 32'd1;
                                m_valid_reg <= 1'b1;
                            end else if (fill_reg == '0) begin
                                status_reg  <= ST_EMPTY;
                                m_valid_reg <= 1'b1;
                            end else begin
                                state_reg <= S_START;
                            end
                        end
                    end
                end
                S_START: begin
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    if (walk_done) begin
                        status_reg  <= status_next;
                        id_reg      <= id_next;
                        plen_reg    <= plen_next;
                        pay_reg     <= pay_next;
                        good_reg    <= good_next;
                        crcerr_reg  <= crcerr_next;
                        fmterr_reg  <= fmterr_next;
                        ovf_reg     <= ovf_next;
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
